// File: hdl/pgad_pkg.sv
`timescale 1ns / 1ps
// Package for the paired group average decimator.
// Holds the register format, parameter defaults and the controller/datapath link types.
package pgad_pkg;

    // group_size register format
    localparam int          CFG_W            = 11;
    localparam logic [10:0] GROUP_SIZE_RESET = 11'd8;

    // defaults for the top-level parameters
    localparam int DEF_MAX_GROUP    = 1024;
    localparam int DEF_SAMPLE_WIDTH = 32;

    // controller -> datapath commands
    typedef struct packed {
        logic accept;    // take the input word into the open group
        logic step;      // one restoring-divide step on both lanes
        logic load_out;  // move the quotients into the output register
    } pgad_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic close;     // the word on the input closes the group
        logic div_last;  // the divider is on its final step
    } pgad_status_t;

endpackage

// File: hdl/pgad_datapath.sv
`timescale 1ns / 1ps
// Datapath: group_size register, running sums, group count, shared-divisor
// restoring divider for both lanes and the output register. Uses pgad_pkg.
module pgad_datapath
    import pgad_pkg::*;
#(
    parameter int MAX_GROUP    = DEF_MAX_GROUP,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [CFG_W-1:0]               cfg_data,
    input  logic signed [SAMPLE_WIDTH-1:0] x_value,
    input  logic signed [SAMPLE_WIDTH-1:0] y_value,
    input  logic                           last,
    input  pgad_cmd_t                      cmd,
    output pgad_status_t                   status,
    output logic signed [SAMPLE_WIDTH-1:0] x_mean,
    output logic signed [SAMPLE_WIDTH-1:0] y_mean,
    output logic                           final_group
);

    localparam int CNT_W  = $clog2(MAX_GROUP + 1);
    localparam int SUM_W  = SAMPLE_WIDTH + $clog2(MAX_GROUP);
    localparam int REM_W  = CNT_W + 1;
    localparam int ITER_W = $clog2(SUM_W + 1);

    logic [CFG_W-1:0]        group_size_reg;
    logic signed [SUM_W-1:0] sum_x_reg, sum_y_reg;
    logic [CNT_W-1:0]        fill_reg;

    logic [SUM_W-1:0]        dvd_x_reg, dvd_y_reg, dvd_x_next, dvd_y_next;
    logic [REM_W-1:0]        rem_x_reg, rem_y_reg, rem_x_next, rem_y_next;
    logic                    neg_x_reg, neg_y_reg, final_reg;
    logic [CNT_W-1:0]        divisor_reg;
    logic [ITER_W-1:0]       iter_reg;

    logic signed [SAMPLE_WIDTH-1:0] x_mean_reg, y_mean_reg;
    logic                           final_group_reg;

    logic [CNT_W-1:0]        limit;
    logic [CNT_W-1:0]        fill_inc;
    logic signed [SUM_W-1:0] sum_x_new, sum_y_new;
    logic [SUM_W-1:0]        mag_x, mag_y;
    logic [REM_W-1:0]        rsh_x, rsh_y;
    logic                    qb_x, qb_y;
    logic [SUM_W-1:0]        q_x_signed, q_y_signed;
    logic                    close_now, div_done;

    // effective group length: zero acts as one, large values saturate
    always_comb
    begin
        if (group_size_reg == '0)
            limit = CNT_W'(1);
        else if (int'(group_size_reg) > MAX_GROUP)
            limit = CNT_W'(MAX_GROUP);
        else
            limit = CNT_W'(group_size_reg);
    end

    // accumulate and decide whether this word closes the group
    always_comb
    begin
        fill_inc  = fill_reg + 1'b1;
        sum_x_new = sum_x_reg + SUM_W'(x_value);
        sum_y_new = sum_y_reg + SUM_W'(y_value);
        mag_x     = sum_x_new[SUM_W-1] ? SUM_W'(-sum_x_new) : SUM_W'(sum_x_new);
        mag_y     = sum_y_new[SUM_W-1] ? SUM_W'(-sum_y_new) : SUM_W'(sum_y_new);
        close_now = (fill_inc >= limit) || last;
    end

    // one restoring step per lane, common divisor
    always_comb
    begin
        rsh_x = {rem_x_reg[REM_W-2:0], dvd_x_reg[SUM_W-1]};
        rsh_y = {rem_y_reg[REM_W-2:0], dvd_y_reg[SUM_W-1]};
        qb_x  = (rsh_x >= {1'b0, divisor_reg});
        qb_y  = (rsh_y >= {1'b0, divisor_reg});
        rem_x_next = qb_x ? (rsh_x - {1'b0, divisor_reg}) : rsh_x;
        rem_y_next = qb_y ? (rsh_y - {1'b0, divisor_reg}) : rsh_y;
        dvd_x_next = {dvd_x_reg[SUM_W-2:0], qb_x};
        dvd_y_next = {dvd_y_reg[SUM_W-2:0], qb_y};
        div_done   = (iter_reg == ITER_W'(1));
    end

    // status to the controller
    assign status = '{close: close_now, div_last: div_done};

    // restore sign of the quotients
    always_comb
    begin
        q_x_signed = neg_x_reg ? (~dvd_x_reg + 1'b1) : dvd_x_reg;
        q_y_signed = neg_y_reg ? (~dvd_y_reg + 1'b1) : dvd_y_reg;
    end

    // config register, sums, count and divider iteration count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_size_reg <= GROUP_SIZE_RESET;
            sum_x_reg      <= '0;
            sum_y_reg      <= '0;
            fill_reg       <= '0;
            iter_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                group_size_reg <= cfg_data;
            if (cmd.accept)
            begin
                if (close_now)
                begin
                    sum_x_reg <= '0;
                    sum_y_reg <= '0;
                    fill_reg  <= '0;
                    iter_reg  <= ITER_W'(SUM_W);
                end
                else
                begin
                    sum_x_reg <= sum_x_new;
                    sum_y_reg <= sum_y_new;
                    fill_reg  <= fill_inc;
                end
            end
            else if (cmd.step)
                iter_reg <= iter_reg - 1'b1;
        end
    end

    // divider operands and partial results
    always_ff @(posedge clk)
    begin
        if (cmd.accept && close_now)
        begin
            dvd_x_reg   <= mag_x;
            dvd_y_reg   <= mag_y;
            rem_x_reg   <= '0;
            rem_y_reg   <= '0;
            neg_x_reg   <= sum_x_new[SUM_W-1];
            neg_y_reg   <= sum_y_new[SUM_W-1];
            divisor_reg <= fill_inc;
            final_reg   <= last;
        end
        else if (cmd.step)
        begin
            dvd_x_reg <= dvd_x_next;
            dvd_y_reg <= dvd_y_next;
            rem_x_reg <= rem_x_next;
            rem_y_reg <= rem_y_next;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            x_mean_reg      <= q_x_signed[SAMPLE_WIDTH-1:0];
            y_mean_reg      <= q_y_signed[SAMPLE_WIDTH-1:0];
            final_group_reg <= final_reg;
        end
    end

    assign x_mean      = x_mean_reg;
    assign y_mean      = y_mean_reg;
    assign final_group = final_group_reg;

endmodule

// File: hdl/pgad_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences accumulate, divide and publish, and owns the
// output valid flag. Uses pgad_pkg for the command and status types.
module pgad_ctrl
    import pgad_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  logic         out_ready,
    input  pgad_status_t status,
    output pgad_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_ACCUM,
        ST_DIVIDE,
        ST_PUBLISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // command decode and next state
    always_comb
    begin
        cmd.accept   = (state_reg == ST_ACCUM) && in_valid;
        cmd.step     = (state_reg == ST_DIVIDE);
        cmd.load_out = (state_reg == ST_PUBLISH) && (!out_valid_reg || out_ready);

        state_next = state_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                if (cmd.accept && status.close)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (status.div_last)
                    state_next = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                if (cmd.load_out)
                    state_next = ST_ACCUM;
            end
            default:
                state_next = ST_ACCUM;
        endcase

        // output word held until taken
        out_valid_next = cmd.load_out || (out_valid_reg && !out_ready);
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_ACCUM);
    assign out_valid = out_valid_reg;

endmodule

// File: hdl/paired_group_average_decimator.sv
`timescale 1ns / 1ps
// Paired group average decimator. Sums x and y of each input word over a group of
// group_size words (1..MAX_GROUP; 0 acts as 1), or up to a word marked last, then
// emits both sums divided by the true count, truncated toward zero. Words of an open
// group are taken one per cycle. The closing word starts a restoring divider that
// handles both lanes with a shared divisor, one quotient bit per cycle, across the
// full sum width; the quotients then go to the output register once it is empty or
// being read. The output register lets the next group gather while a result waits.
// cfg_ready is always high. Depends on pgad_pkg, pgad_ctrl and pgad_datapath.
module paired_group_average_decimator
    import pgad_pkg::*;
#(
    parameter int MAX_GROUP    = DEF_MAX_GROUP,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_W-1:0]               group_size,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] x_value,
    input  logic signed [SAMPLE_WIDTH-1:0] y_value,
    input  logic                           last,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] x_mean,
    output logic signed [SAMPLE_WIDTH-1:0] y_mean,
    output logic                           final_group
);

    pgad_cmd_t    cmd;
    pgad_status_t status;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    pgad_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    pgad_datapath #(
        .MAX_GROUP    (MAX_GROUP),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid),
        .cfg_data    (group_size),
        .x_value     (x_value),
        .y_value     (y_value),
        .last        (last),
        .cmd         (cmd),
        .status      (status),
        .x_mean      (x_mean),
        .y_mean      (y_mean),
        .final_group (final_group)
    );

endmodule

// File: sim/paired_group_average_decimator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for paired_group_average_decimator: random and directed x/y words,
// an in-bench group-mean predictor and an in-order result checker. Depends on pgad_pkg
// and the paired_group_average_decimator RTL.
module paired_group_average_decimator_tb;
    import pgad_pkg::*;

    localparam int SW          = DEF_SAMPLE_WIDTH;
    localparam int MAX_GROUP   = DEF_MAX_GROUP;
    localparam int SETTLE      = 64;        // divider plus output load, with margin
    localparam int LONG_HOLD   = 400;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
        logic                 closes;
    } pair_word_t;

    typedef struct packed {
        logic signed [SW-1:0] x_mean;
        logic signed [SW-1:0] y_mean;
        logic                 final_group;
    } mean_pair_t;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_pattern_t;

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_valid   = 1'b0;
    logic                 cfg_ready;
    logic [CFG_W-1:0]     group_size  = GROUP_SIZE_RESET;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic signed [SW-1:0] x_value     = '0;
    logic signed [SW-1:0] y_value     = '0;
    logic                 last        = 1'b0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic signed [SW-1:0] x_mean;
    logic signed [SW-1:0] y_mean;
    logic                 final_group;

    // stimulus and expectation stores
    pair_word_t pending_words[$];
    mean_pair_t expected_means[$];
    int         words_queued = 0;
    int         words_sent   = 0;
    int         mismatches   = 0;
    int         cycle_count  = 0;

    // predictor state
    logic [CFG_W-1:0] size_setting = GROUP_SIZE_RESET;
    longint           sum_x        = 0;
    longint           sum_y        = 0;
    int               fill         = 0;

    // sender burst state
    int burst_left = 4;
    int gap_left   = 0;

    // receiver state
    int          holds_asked  = 0;
    int          holds_done   = 0;
    int          hold_left    = 0;
    int          pattern_left = 0;
    rx_pattern_t pattern_mode = RX_OPEN;

    paired_group_average_decimator uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .group_size  (group_size),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .x_value     (x_value),
        .y_value     (y_value),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .x_mean      (x_mean),
        .y_mean      (y_mean),
        .final_group (final_group)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Add one accepted word into the open group; close it on a full count or on last.
    function automatic void accumulate_pair(input logic signed [SW-1:0] xs,
                                            input logic signed [SW-1:0] ys,
                                            input logic closes);
        int                  limit;
        logic signed [63:0]  quot;
        mean_pair_t          result;
        limit = (size_setting == 0) ? 1 : int'(size_setting);
        if (limit > MAX_GROUP)
            limit = MAX_GROUP;
        sum_x = sum_x + xs;
        sum_y = sum_y + ys;
        fill  = fill + 1;
        if (fill >= limit || closes)
        begin
            // signed divide truncates toward zero
            quot = sum_x / longint'(fill);
            result.x_mean = quot[SW-1:0];
            quot = sum_y / longint'(fill);
            result.y_mean = quot[SW-1:0];
            result.final_group = closes;
            expected_means.push_back(result);
            sum_x = 0;
            sum_y = 0;
            fill  = 0;
        end
    endfunction

    function automatic logic [SW-1:0] pick_sample();
        int near_zero;
        near_zero = int'($urandom_range(0, 16)) - 8;
        case ($urandom_range(0, 9))
            0:       return {1'b0, {(SW-1){1'b1}}};
            1:       return {1'b1, {(SW-1){1'b0}}};
            2, 3:    return SW'(near_zero);
            default: return SW'($urandom());
        endcase
    endfunction

    task automatic queue_pair(input logic [SW-1:0] xs, input logic [SW-1:0] ys,
                              input logic closes);
        pair_word_t w;
        w.x = xs;
        w.y = ys;
        w.closes = closes;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // random words; the run always ends on last so no group stays open
    task automatic queue_random_run(input int count, input int last_pct);
        for (int i = 0; i < count; i++)
            queue_pair(pick_sample(), pick_sample(),
                       (i == count - 1) || ($urandom_range(1, 100) <= last_pct));
    endtask

    // sender pause: wait for every word to go in and every mean to come out
    task automatic drain_words();
        while (words_sent != words_queued || expected_means.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_group_size(input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid  <= 1'b1;
        group_size <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        size_setting = value;
    endtask

    task automatic run_setting(input logic [CFG_W-1:0] value, input int count,
                               input int last_pct);
        write_group_size(value);
        queue_random_run(count, last_pct);
        drain_words();
    endtask

    // Driver: present queued words in bursts with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        pair_word_t next_word;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            x_value    <= '0;
            y_value    <= '0;
            last       <= 1'b0;
            burst_left = 4;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                accumulate_pair(x_value, y_value, last);
                words_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    next_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    x_value  <= next_word.x;
                    y_value  <= next_word.y;
                    last     <= next_word.closes;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 3))
                            1:       gap_left = $urandom_range(1, 3);
                            2:       gap_left = $urandom_range(4, 12);
                            default: gap_left = 0;
                        endcase
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted mean and drive out_ready on its own pattern.
    always @(posedge clk or negedge rst_n)
    begin
        mean_pair_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_means.size() == 0)
                begin
                    $display("%0t: unexpected word x_mean %0d y_mean %0d final_group %0b",
                             $time, x_mean, y_mean, final_group);
                    mismatches++;
                end
                else
                begin
                    want = expected_means.pop_front();
                    if (x_mean !== want.x_mean)
                    begin
                        $display("%0t: x_mean expected %0d actual %0d",
                                 $time, want.x_mean, x_mean);
                        mismatches++;
                    end
                    if (y_mean !== want.y_mean)
                    begin
                        $display("%0t: y_mean expected %0d actual %0d",
                                 $time, want.y_mean, y_mean);
                        mismatches++;
                    end
                    if (final_group !== want.final_group)
                    begin
                        $display("%0t: final_group expected %0b actual %0b",
                                 $time, want.final_group, final_group);
                        mismatches++;
                    end
                end
            end

            // long hold on request, otherwise a randomly chosen pattern that is redrawn when its span runs out
            if (holds_done != holds_asked)
            begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (pattern_left == 0)
                begin
                    pattern_mode = rx_pattern_t'($urandom_range(0, 3));
                    pattern_left = $urandom_range(16, 96);
                end
                pattern_left--;
                case (pattern_mode)
                    RX_OPEN:   out_ready <= 1'b1;
                    RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: out_ready <= (pattern_left % 4 == 0);
                    default:   out_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("paired_group_average_decimator: mismatch");
            $finish;
        end
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset group size of 8: a full group at both extremes
        repeat (8) queue_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        // partial group by last; negative mean truncates toward zero
        queue_pair(-32'sd7, 32'sd5, 1'b0);
        queue_pair(32'sd0, 32'sd1, 1'b0);
        queue_pair(32'sd0, 32'sd1, 1'b1);
        // last landing on a full group gives a single mean
        for (int i = 0; i < 8; i++)
            queue_pair(pick_sample(), pick_sample(), i == 7);
        // group of one closed by last
        queue_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        drain_words();

        // size zero acts as one
        write_group_size(11'd0);
        queue_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
        queue_pair(-32'sd1, 32'sd1, 1'b1);
        drain_words();

        // size one under a long receiver hold: the block fills and stalls its input
        write_group_size(11'd1);
        holds_asked++;
        queue_random_run(60, 10);
        drain_words();

        run_setting(11'd2, 30, 10);
        run_setting(11'd3, 30, 10);
        run_setting(11'd0, 25, 10);
        run_setting(11'd5, 30, 10);
        run_setting(11'd8, 32, 8);
        run_setting(11'($urandom_range(1, 16)), 30, 10);
        run_setting(11'($urandom_range(9, 40)), 40, 4);
        run_setting(11'd1, 30, 20);

        // largest group: extreme sums in a partial group closed by last
        write_group_size(11'd1024);
        repeat (60) queue_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        queue_random_run(20, 0);
        drain_words();

        // all register bits set: saturates to the largest group, no early close
        write_group_size(11'h7FF);
        for (int i = 0; i < 30; i++)
            queue_pair(pick_sample(), pick_sample(), 1'b0);
        queue_random_run(7, 0);
        drain_words();

        run_setting(11'd4, 12, 10);

        if (mismatches == 0 && expected_means.size() == 0)
            $display("paired_group_average_decimator: match");
        else
            $display("paired_group_average_decimator: mismatch");
        $finish;
    end

endmodule
